// ===== rtl/core/tpo_pkg.sv =====
// Package: widths, payload types and state codes for the totalizer pulse output unit.
`timescale 1ns / 1ps
package tpo_pkg;

	localparam int TOTAL_BITS = 32;
	localparam int CNT_BITS = $clog2(TOTAL_BITS);
	localparam logic [15:0] PULSE_DURATION_RST = 16'd100;

	typedef logic [TOTAL_BITS-1:0] total_t;

	typedef struct packed {
		logic        dose_active;
		logic        step_changed;
		logic [31:0] new_step;
		logic        total_changed;
		logic [31:0] total_value;
	} poll_t;

	typedef struct packed {
		logic        pulse_fire;
		logic [15:0] pulse_length;
		logic [31:0] multiples_done;
		logic        running;
	} pulse_t;

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_DIV  = 3'b010,
		S_DONE = 3'b100
	} state_t;

endpackage

// ===== rtl/core/tpo_poll_if.sv =====
// Interface: poll item channel (valid/ready with payload).
`timescale 1ns / 1ps
interface tpo_poll_if;
	logic           valid;
	logic           ready;
	tpo_pkg::poll_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/core/tpo_pulse_if.sv =====
// Interface: pulse result channel (valid/ready with payload).
`timescale 1ns / 1ps
interface tpo_pulse_if;
	logic            valid;
	logic            ready;
	tpo_pkg::pulse_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/core/totalizer_pulse_output_unit.sv =====
// Top level: totalizer pulse output unit with bit-serial multiple count divider.
`timescale 1ns / 1ps
// Each poll beat yields one result beat. A beat that needs no division (idle,
// start or stop of a run, no fresh total, or a zero step) is answered in the
// cycle after acceptance. A fresh total with a nonzero step runs a restoring
// divider in S_DIV, one quotient bit per cycle, then waits in S_DONE until the
// output register is free. One beat is worked on at a time; a finished result
// sits in an output register, and the next poll beat is taken as soon as that
// register is free or being drained. The user writes pulse_duration through
// cfg_we/cfg_wdata while the unit is idle; the unit itself does not enforce it.
module totalizer_pulse_output_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	tpo_poll_if.sink    poll,
	tpo_pulse_if.source pulse
);

	localparam int TB = tpo_pkg::TOTAL_BITS;
	localparam int CW = tpo_pkg::CNT_BITS;

	tpo_pkg::state_t state_q;
	logic [15:0]     duration_q;
	logic            run_q;
	tpo_pkg::total_t step_q;
	tpo_pkg::total_t start_q;
	tpo_pkg::total_t last_q;
	tpo_pkg::total_t count_q;
	tpo_pkg::total_t quo_q;
	tpo_pkg::total_t rem_q;
	logic [CW-1:0]   cnt_q;
	logic            out_valid_q;
	tpo_pkg::pulse_t out_data_q;

	logic            out_free;
	logic            accept;
	logic            out_load;
	tpo_pkg::total_t tot;
	tpo_pkg::total_t nstep;
	logic            run_n;
	tpo_pkg::total_t step_n;
	tpo_pkg::total_t start_n;
	tpo_pkg::total_t last_n;
	tpo_pkg::total_t count_n;
	logic            div_go;
	tpo_pkg::total_t diff;
	logic [TB:0]     shifted;
	logic [TB:0]     trial;
	logic            qbit;
	logic            more;

	assign out_free   = !out_valid_q || pulse.ready;
	assign poll.ready = (state_q == tpo_pkg::S_IDLE) && out_free;
	assign accept     = poll.valid && poll.ready;
	assign tot        = TB'(poll.payload.total_value);
	assign nstep      = TB'(poll.payload.new_step);
	assign out_load   = (accept && !div_go) || (state_q == tpo_pkg::S_DONE && out_free);

	always_comb begin
		run_n   = run_q;
		step_n  = step_q;
		start_n = start_q;
		last_n  = last_q;
		count_n = count_q;
		div_go  = 1'b0;
		if (!run_q) begin
			if (poll.payload.dose_active) begin
				run_n = 1'b1;
				if (poll.payload.step_changed) begin
					step_n = nstep;
				end
				start_n = tot;
				last_n  = tot;
				count_n = '0;
			end
		end else if (!poll.payload.dose_active) begin
			run_n = 1'b0;
		end else begin
			if (poll.payload.step_changed) begin
				step_n  = nstep;
				count_n = '0;
			end
			if (poll.payload.total_changed) begin
				// totalizer was zeroed: restart from the new reading
				if (tot < last_q) begin
					start_n = tot;
					count_n = '0;
				end
				if (step_n != '0) begin
					div_go = 1'b1;
					last_n = tot;
				end
			end
		end
		diff = (tot >= start_n) ? (tot - start_n) : '0;
	end

	// one restoring divide step: bring down the next dividend bit
	assign shifted = {rem_q, quo_q[TB-1]};
	assign trial   = shifted - {1'b0, step_q};
	assign qbit    = !trial[TB];
	assign more    = quo_q > count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= tpo_pkg::S_IDLE;
			duration_q  <= tpo_pkg::PULSE_DURATION_RST;
			run_q       <= 1'b0;
			step_q      <= '0;
			start_q     <= '0;
			last_q      <= '0;
			count_q     <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				duration_q <= cfg_wdata;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (pulse.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				tpo_pkg::S_IDLE: begin
					if (accept) begin
						run_q   <= run_n;
						step_q  <= step_n;
						start_q <= start_n;
						last_q  <= last_n;
						count_q <= count_n;
						if (div_go) begin
							cnt_q   <= CW'(TB - 1);
							state_q <= tpo_pkg::S_DIV;
						end
					end
				end
				tpo_pkg::S_DIV: begin
					if (cnt_q == '0) begin
						state_q <= tpo_pkg::S_DONE;
					end else begin
						cnt_q <= cnt_q - CW'(1);
					end
				end
				tpo_pkg::S_DONE: begin
					if (out_free) begin
						if (more) begin
							count_q <= quo_q;
						end
						state_q <= tpo_pkg::S_IDLE;
					end
				end
				default: begin
					state_q <= tpo_pkg::S_IDLE;
				end
			endcase
		end
	end

	// divider datapath and result register
	always_ff @(posedge clk) begin
		if (state_q == tpo_pkg::S_IDLE && accept) begin
			quo_q <= diff;
			rem_q <= '0;
			out_data_q.pulse_fire     <= 1'b0;
			out_data_q.pulse_length   <= '0;
			out_data_q.multiples_done <= 32'(count_n);
			out_data_q.running        <= run_n;
		end else if (state_q == tpo_pkg::S_DIV) begin
			quo_q <= {quo_q[TB-2:0], qbit};
			rem_q <= qbit ? trial[TB-1:0] : shifted[TB-1:0];
		end else if (state_q == tpo_pkg::S_DONE && out_free) begin
			out_data_q.pulse_fire     <= more;
			out_data_q.pulse_length   <= more ? duration_q : '0;
			out_data_q.multiples_done <= more ? 32'(quo_q) : 32'(count_q);
			out_data_q.running        <= run_q;
		end
	end

	assign pulse.valid   = out_valid_q;
	assign pulse.payload = out_data_q;

endmodule

// ===== dv/tb_totalizer_pulse_output_unit.sv =====
// Testbench for the totalizer pulse output unit: directed and random poll beats, scoreboard check.
`timescale 1ns / 1ps

class pulse_scoreboard;
	tpo_pkg::pulse_t expected_pulses[$];
	logic            run_flag;
	tpo_pkg::total_t step_size;
	tpo_pkg::total_t start_total;
	tpo_pkg::total_t last_total;
	tpo_pkg::total_t multiples;
	logic [15:0]     duration;
	int              errors;

	function new();
		run_flag = 1'b0;
		step_size = '0;
		start_total = '0;
		last_total = '0;
		multiples = '0;
		duration = tpo_pkg::PULSE_DURATION_RST;
		errors = 0;
	endfunction

	// Advances the pulse generator state by one poll beat and returns its result.
	function tpo_pkg::pulse_t next_pulse(tpo_pkg::poll_t p);
		tpo_pkg::pulse_t r;
		tpo_pkg::total_t diff;
		tpo_pkg::total_t n;
		r = '0;
		if (!run_flag) begin
			if (p.dose_active) begin
				run_flag = 1'b1;
				if (p.step_changed)
					step_size = p.new_step;
				// start point is latched even from a stale reading
				start_total = p.total_value;
				last_total = p.total_value;
				multiples = '0;
			end
		end else if (!p.dose_active) begin
			run_flag = 1'b0;
		end else begin
			if (p.step_changed) begin
				step_size = p.new_step;
				multiples = '0;
			end
			if (p.total_changed) begin
				if (p.total_value < last_total) begin
					start_total = p.total_value;
					multiples = '0;
				end
				if (step_size != '0) begin
					diff = (p.total_value >= start_total) ? p.total_value - start_total : '0;
					n = diff / step_size;
					if (n > multiples) begin
						multiples = n;
						r.pulse_fire = 1'b1;
						r.pulse_length = duration;
					end
					last_total = p.total_value;
				end
			end
		end
		r.multiples_done = 32'(multiples);
		r.running = run_flag;
		return r;
	endfunction

	function void note_poll(tpo_pkg::poll_t p);
		expected_pulses.push_back(next_pulse(p));
	endfunction

	function void check_pulse(tpo_pkg::pulse_t got);
		tpo_pkg::pulse_t want;
		if (expected_pulses.size() == 0) begin
			$error("result beat with no poll beat pending");
			errors++;
			return;
		end
		want = expected_pulses.pop_front();
		if (got.pulse_fire !== want.pulse_fire) begin
			$error("pulse_fire: expected %0d, actual %0d", want.pulse_fire, got.pulse_fire);
			errors++;
		end
		if (got.pulse_length !== want.pulse_length) begin
			$error("pulse_length: expected %0d, actual %0d", want.pulse_length,
				got.pulse_length);
			errors++;
		end
		if (got.multiples_done !== want.multiples_done) begin
			$error("multiples_done: expected %0d, actual %0d", want.multiples_done,
				got.multiples_done);
			errors++;
		end
		if (got.running !== want.running) begin
			$error("running: expected %0d, actual %0d", want.running, got.running);
			errors++;
		end
	endfunction
endclass

module tb_totalizer_pulse_output_unit;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [15:0] cfg_wdata;

	tpo_poll_if  poll_ch ();
	tpo_pulse_if pulse_ch ();

	pulse_scoreboard sb;
	int unsigned     dosing_items;
	bit              no_gaps;
	logic [31:0]     level;
	logic [31:0]     gen_step;

	totalizer_pulse_output_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.poll      (poll_ch),
		.pulse     (pulse_ch)
	);

	initial clk = 1'b0;
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (pulse_ch.valid && pulse_ch.ready)
				sb.check_pulse(pulse_ch.payload);
			if (poll_ch.valid && poll_ch.ready)
				sb.note_poll(poll_ch.payload);
		end
	end

	// mostly short gaps, now and then a long one
	function automatic int unsigned gap_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [31:0] pick_step();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 6)
			return '0;
		else if (r < 12)
			return $urandom;
		else if (r < 20)
			return 32'h1 << $urandom_range(0, 31);
		else if (r < 25)
			return 32'hFFFF_FFFF;
		return $urandom_range(1, 1000);
	endfunction

	task automatic send_poll(input bit dose, input bit step_fresh, input logic [31:0] step,
			input bit total_fresh, input logic [31:0] total);
		tpo_pkg::poll_t p;
		int unsigned    g;
		p.dose_active = dose;
		p.step_changed = step_fresh;
		p.new_step = step;
		p.total_changed = total_fresh;
		p.total_value = total;
		g = no_gaps ? 0 : gap_len();
		if (g != 0) begin
			poll_ch.valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		poll_ch.valid <= 1'b1;
		poll_ch.payload <= p;
		@(posedge clk);
		while (!poll_ch.ready) @(posedge clk);
		if (dose)
			dosing_items++;
	endtask

	task automatic write_duration(input logic [15:0] value);
		poll_ch.valid <= 1'b0;
		@(posedge clk);
		while (sb.expected_pulses.size() != 0) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.duration = value;
	endtask

	function automatic logic [31:0] pick_increment();
		if (gen_step == '0 || gen_step > 32'h0010_0000)
			return ($urandom_range(0, 1) != 0) ? $urandom : $urandom_range(0, 5000);
		else if ($urandom_range(0, 9) == 0)
			return $urandom_range(0, 10 * gen_step);
		return $urandom_range(0, 3 * gen_step);
	endfunction

	// One dosing run: up to two idle beats, start, a body of mostly rising readings, then stop.
	task automatic random_run();
		int unsigned len;
		int unsigned r;
		bit          fresh;
		logic [31:0] s;
		no_gaps = ($urandom_range(0, 4) == 0);
		repeat ($urandom_range(0, 2))
			send_poll(1'b0, 1'($urandom_range(0, 1)), $urandom, 1'($urandom_range(0, 1)),
				$urandom);
		fresh = ($urandom_range(0, 3) != 0);
		s = pick_step();
		if (fresh)
			gen_step = s;
		level = ($urandom_range(0, 1) != 0) ? $urandom : $urandom_range(0, 100000);
		send_poll(1'b1, fresh, fresh ? s : $urandom, 1'($urandom_range(0, 1)), level);
		len = $urandom_range(4, 50);
		repeat (len) begin
			r = $urandom_range(0, 99);
			if (r < 8) begin
				gen_step = pick_step();
				fresh = ($urandom_range(0, 4) != 0);
				if (fresh)
					level = level + pick_increment();
				send_poll(1'b1, 1'b1, gen_step, fresh, fresh ? level : $urandom);
			end else if (r < 12) begin
				// totalizer zeroed
				level = $urandom_range(0, 3 * (gen_step > 1000 ? 1000 : gen_step));
				send_poll(1'b1, 1'b0, $urandom, 1'b1, level);
			end else if (r < 20) begin
				send_poll(1'b1, 1'b0, $urandom, 1'b0, $urandom);
			end else begin
				level = level + pick_increment();
				send_poll(1'b1, 1'b0, $urandom, 1'b1, level);
			end
		end
		send_poll(1'b0, 1'($urandom_range(0, 1)), $urandom, 1'($urandom_range(0, 1)),
			$urandom);
	endtask

	initial begin
		int unsigned pulses_target;
		logic [15:0] durations [6];
		sb = new();
		dosing_items = 0;
		no_gaps = 1'b0;
		gen_step = '0;
		level = '0;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_wdata <= '0;
		poll_ch.valid <= 1'b0;
		poll_ch.payload <= '0;
		durations[0] = 16'hFFFF;
		durations[1] = 16'h0000;
		durations[2] = 16'($urandom);
		durations[3] = 16'h0001;
		durations[4] = 16'($urandom);
		durations[5] = 16'h8000;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed beats, reset value of the pulse length
		send_poll(1'b0, 1'b1, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF);
		send_poll(1'b1, 1'b1, 32'd10, 1'b0, 32'd1000);
		send_poll(1'b1, 1'b0, 32'd0, 1'b1, 32'd1005);
		send_poll(1'b1, 1'b0, 32'hFFFF_FFFF, 1'b1, 32'd1010);
		send_poll(1'b1, 1'b0, 32'd0, 1'b1, 32'd1010);
		send_poll(1'b1, 1'b0, 32'd0, 1'b1, 32'd1045);
		send_poll(1'b1, 1'b0, 32'd0, 1'b0, 32'hDEAD_BEEF);
		send_poll(1'b1, 1'b1, 32'd20, 1'b1, 32'd1060);
		send_poll(1'b1, 1'b0, 32'd0, 1'b1, 32'd5);
		send_poll(1'b1, 1'b0, 32'd0, 1'b1, 32'd25);
		send_poll(1'b1, 1'b1, 32'd0, 1'b1, 32'd100);
		send_poll(1'b1, 1'b0, 32'd0, 1'b1, 32'd10);
		send_poll(1'b1, 1'b1, 32'd1, 1'b1, 32'hFFFF_FFFF);
		send_poll(1'b1, 1'b1, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF);
		send_poll(1'b0, 1'b1, 32'd5, 1'b1, 32'd7);
		send_poll(1'b0, 1'b0, 32'd0, 1'b0, 32'd0);
		send_poll(1'b1, 1'b0, 32'd0, 1'b0, 32'd0);
		send_poll(1'b1, 1'b0, 32'd0, 1'b1, 32'hFFFF_FFFF);
		send_poll(1'b1, 1'b0, 32'd0, 1'b1, 32'hFFFF_FFFE);
		send_poll(1'b1, 1'b1, 32'd0, 1'b0, 32'd0);
		send_poll(1'b0, 1'b0, 32'd0, 1'b0, 32'd0);
		send_poll(1'b1, 1'b1, 32'd0, 1'b1, 32'd500);
		send_poll(1'b1, 1'b0, 32'd0, 1'b1, 32'd600);
		send_poll(1'b1, 1'b1, 32'd100, 1'b1, 32'd600);
		send_poll(1'b0, 1'b0, 32'd0, 1'b0, 32'd0);

		for (int ph = 0; ph < 6; ph++) begin
			write_duration(durations[ph]);
			pulses_target = dosing_items + 200;
			while (dosing_items < pulses_target)
				random_run();
		end

		poll_ch.valid <= 1'b0;
		@(posedge clk);
		while (sb.expected_pulses.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (sb.errors == 0 && sb.expected_pulses.size() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

	// result side: random stalls, sometimes long stretches held ready
	initial begin
		int unsigned g;
		pulse_ch.ready <= 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			g = gap_len();
			if (g != 0) begin
				pulse_ch.ready <= 1'b0;
				repeat (g) @(posedge clk);
			end
			pulse_ch.ready <= 1'b1;
			repeat (($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 12))
				@(posedge clk);
		end
	end

	initial begin
		#5000000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
